// ----- hdl/wsd_pkg.sv -----
`default_nettype none

package wsd_pkg;

	// Commands on the input channel.
	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_OPEN = 2'd1;
	localparam logic [1:0] CMD_LOST = 2'd2;

	// Close causes reported with the closing result.
	localparam logic [1:0] CLOSE_NONE   = 2'd0;
	localparam logic [1:0] CLOSE_OPCODE = 2'd1;
	localparam logic [1:0] CLOSE_LEN64  = 2'd2;
	localparam logic [1:0] CLOSE_LINK   = 2'd3;

	// Header field constants.
	localparam logic [3:0] OPCODE_MASK  = 4'hF;
	localparam logic [3:0] OPC_CLOSE    = 4'd8;
	localparam logic [6:0] LEN_CODE_16  = 7'd126;
	localparam logic [6:0] LEN_CODE_64  = 7'd127;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_out;
		logic       session_active;
		logic [1:0] close_cause;
	} out_item_t;

	// Item class decided by the front.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OPEN = 2'd1,
		KIND_LOST = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] rx_byte;
	} entry_t;

	// Head of the queue as seen by the back.
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} queue_head_t;

	// Parser phases, one-hot.
	typedef enum logic [8:0] {
		PH_HDR0 = 9'b000000001,
		PH_HDR1 = 9'b000000010,
		PH_EXT0 = 9'b000000100,
		PH_EXT1 = 9'b000001000,
		PH_KEY0 = 9'b000010000,
		PH_KEY1 = 9'b000100000,
		PH_KEY2 = 9'b001000000,
		PH_KEY3 = 9'b010000000,
		PH_DATA = 9'b100000000
	} phase_t;

endpackage

`default_nettype wire

// ----- hdl/websocket_frame_deframer_core.sv -----
// WebSocket receive deframer for one session.
// The input channel (item_valid, item_ready, item) carries one beat per link event:
// a received byte, a session-open command or a link-lost command.
// The output channel (result_valid, result_ready, result) returns exactly one beat
// per input beat, in order: the unmasked payload character when one is delivered,
// whether the session is still open, and the cause when this beat closed it.
// A beat is classified as it is accepted and written into a two-entry queue; the
// parser pops it from the queue and registers its result in the result register,
// from which the receiver takes it. One beat per cycle is sustained in both
// directions while the receiver does not stall; the rate is set by the parser,
// which takes one beat per step.
// When the receiver stalls, the result register holds its beat, the queue fills
// and item_ready drops once both queue entries are taken; nothing is lost.
// Reset empties the queue and the result register and returns the parser to the
// first header byte with no session open.
`default_nettype none

module websocket_frame_deframer_core #(
	parameter int PAYLOAD_LIMIT = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire wsd_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output wsd_pkg::out_item_t      result
);
	import wsd_pkg::*;

	logic        queue_full;
	logic        push;
	entry_t      push_entry;
	logic        pop;
	queue_head_t head;

	// Front: accept the beat and classify its command.
	wsd_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Short queue that decouples acceptance from parsing.
	wsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head       (head)
	);

	// Back: frame parser, unmasking and the result register.
	wsd_back #(
		.PAYLOAD_LIMIT (PAYLOAD_LIMIT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef SYNTH
	// A closing beat always reports the session as closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.close_cause != CLOSE_NONE) |-> !result.session_active)
		else $error("close reported with session still active");

	// A character is only delivered inside an open session.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.char_valid |-> result.session_active)
		else $error("character delivered without a session");

	// Without a delivered character the character field stays zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.char_valid |-> (result.char_out == 8'h00))
		else $error("character field not cleared");

	// A character beat never carries a close cause.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.char_valid |-> (result.close_cause == CLOSE_NONE))
		else $error("character beat carries a close cause");
`endif

endmodule

`default_nettype wire

// ----- hdl/wsd_front.sv -----
`default_nettype none

module wsd_front (
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire wsd_pkg::in_item_t item,
	input  wire logic             queue_full,
	output logic                  push,
	output wsd_pkg::entry_t       push_entry
);
	import wsd_pkg::*;

	assign item_ready = !queue_full;
	assign push       = item_valid && !queue_full;

	// Sort the command into the class that the back acts on.
	always_comb begin
		push_entry.rx_byte = item.rx_byte;
		unique case (item.command)
			CMD_DATA: push_entry.kind = KIND_DATA;
			CMD_OPEN: push_entry.kind = KIND_OPEN;
			CMD_LOST: push_entry.kind = KIND_LOST;
			default:  push_entry.kind = KIND_NONE;
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/wsd_queue.sv -----
`default_nettype none

module wsd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire wsd_pkg::entry_t push_entry,
	output logic                 full,
	input  wire logic            pop,
	output wsd_pkg::queue_head_t head
);
	import wsd_pkg::*;

	entry_t                   slots_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/wsd_back.sv -----
`default_nettype none

module wsd_back #(
	parameter int PAYLOAD_LIMIT = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire wsd_pkg::queue_head_t  head,
	output logic                       pop,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output wsd_pkg::out_item_t         result
);
	import wsd_pkg::*;

	localparam logic [16:0] LIMIT = 17'(PAYLOAD_LIMIT);

	logic            session_q,  session_n;
	phase_t          phase_q,    phase_n;
	logic [3:0]      opcode_q,   opcode_n;
	logic            mask_q,     mask_n;
	logic [15:0]     len_q,      len_n;
	logic [15:0]     idx_q,      idx_n;
	logic [3:0][7:0] key_q,      key_n;
	out_item_t       res_n;
	logic            out_valid_q;
	out_item_t       out_q;

	logic [7:0]      b;
	logic [6:0]      code;
	logic [15:0]     idx_inc;

	// The output slot takes a new beat when it is empty or being drained.
	assign pop          = head.valid && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign b       = head.entry.rx_byte;
	assign code    = b[6:0];
	assign idx_inc = idx_q + 16'd1;

	always_comb begin
		session_n = session_q;
		phase_n   = phase_q;
		opcode_n  = opcode_q;
		mask_n    = mask_q;
		len_n     = len_q;
		idx_n     = idx_q;
		key_n     = key_q;
		res_n     = '0;

		unique case (head.entry.kind)
			KIND_OPEN: begin
				session_n = 1'b1;
				phase_n   = PH_HDR0;
				opcode_n  = '0;
				mask_n    = 1'b0;
				len_n     = '0;
				idx_n     = '0;
				key_n     = '0;
			end
			KIND_LOST: begin
				if (session_q) begin
					session_n         = 1'b0;
					phase_n           = PH_HDR0;
					opcode_n          = '0;
					mask_n            = 1'b0;
					len_n             = '0;
					idx_n             = '0;
					key_n             = '0;
					res_n.close_cause = CLOSE_LINK;
				end
			end
			KIND_DATA: begin
				if (session_q) begin
					unique case (phase_q)
						PH_HDR0: begin
							opcode_n = b[3:0] & OPCODE_MASK;
							phase_n  = PH_HDR1;
						end
						PH_HDR1: begin
							if (opcode_q == OPC_CLOSE || code == LEN_CODE_64) begin
								session_n         = 1'b0;
								phase_n           = PH_HDR0;
								opcode_n          = '0;
								mask_n            = 1'b0;
								len_n             = '0;
								idx_n             = '0;
								key_n             = '0;
								res_n.close_cause = (opcode_q == OPC_CLOSE) ?
									CLOSE_OPCODE : CLOSE_LEN64;
							end else begin
								mask_n = b[7];
								key_n  = '0;
								if (code == LEN_CODE_16) begin
									phase_n = PH_EXT0;
								end else begin
									len_n = {9'd0, code};
									if (b[7]) begin
										phase_n = PH_KEY0;
									end else begin
										idx_n   = '0;
										phase_n = (code == 7'd0) ? PH_HDR0 : PH_DATA;
									end
								end
							end
						end
						PH_EXT0: begin
							len_n   = {b, 8'h00};
							phase_n = PH_EXT1;
						end
						PH_EXT1: begin
							len_n = {len_q[15:8], b};
							if (mask_q) begin
								phase_n = PH_KEY0;
							end else begin
								idx_n   = '0;
								phase_n = ({len_q[15:8], b} == 16'd0) ? PH_HDR0 : PH_DATA;
							end
						end
						PH_KEY0: begin
							key_n[0] = b;
							phase_n  = PH_KEY1;
						end
						PH_KEY1: begin
							key_n[1] = b;
							phase_n  = PH_KEY2;
						end
						PH_KEY2: begin
							key_n[2] = b;
							phase_n  = PH_KEY3;
						end
						PH_KEY3: begin
							key_n[3] = b;
							idx_n    = '0;
							phase_n  = (len_q == 16'd0) ? PH_HDR0 : PH_DATA;
						end
						PH_DATA: begin
							if ({1'b0, len_q} < LIMIT) begin
								res_n.char_valid = 1'b1;
								res_n.char_out   = b ^ key_q[idx_q[1:0]];
							end
							idx_n = idx_inc;
							if (idx_inc == len_q) begin
								phase_n = PH_HDR0;
							end
						end
						default: begin
							phase_n  = PH_HDR0;
							opcode_n = '0;
							mask_n   = 1'b0;
							len_n    = '0;
							idx_n    = '0;
							key_n    = '0;
						end
					endcase
				end
			end
			default: ;
		endcase

		res_n.session_active = session_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q   <= 1'b0;
			phase_q     <= PH_HDR0;
			opcode_q    <= '0;
			mask_q      <= 1'b0;
			len_q       <= '0;
			idx_q       <= '0;
			key_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				session_q   <= session_n;
				phase_q     <= phase_n;
				opcode_q    <= opcode_n;
				mask_q      <= mask_n;
				len_q       <= len_n;
				idx_q       <= idx_n;
				key_q       <= key_n;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_n;
		end
	end

endmodule

`default_nettype wire
